### rtl/rqs_pkg.sv
// ----------------------------------------------------------------------------
// rqs_pkg
// Shared types and constants for the ready queue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rqs_pkg;

   localparam int QueueDepthDefault = 16;
   localparam int IdBitsDefault     = 8;

   // Fixed field widths of the request and response beats
   localparam int CMD_W   = 3;
   localparam int PID_W   = 8;
   localparam int COUNT_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD      = 3'd0,
      CMD_REMOVE   = 3'd1,
      CMD_NEXT     = 3'd2,
      CMD_DISPATCH = 3'd3,
      CMD_YIELD    = 3'd4
   } cmd_type;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      cmd_type           command;
      logic [PID_W-1:0]  process_id;
      logic              transition_ok;
   } req_payload_type;

   typedef struct packed {
      logic                status;
      logic                popped_valid;
      logic [PID_W-1:0]    popped_id;
      logic                running_valid;
      logic [PID_W-1:0]    running_id;
      logic [COUNT_W-1:0]  ready_count;
   } rsp_payload_type;

endpackage

`default_nettype wire

### rtl/rqs_ram.sv
// ----------------------------------------------------------------------------
// rqs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]          wr_data,
   input  wire logic                      rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
   output      logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/ready_queue_scheduler.sv
// ----------------------------------------------------------------------------
// ready_queue_scheduler
// Round-robin ready queue of process ids kept in a RAM, plus one running id.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake          beat
//   req_     in   req_valid/stall    req_payload (command, process_id, ok)
//   rsp_     out  rsp_valid/stall    rsp_payload (status, popped, running, count)
//
// One command at a time. Add, yield and unused codes go from EXEC to DONE;
// next and dispatch pass through POP as well (one RAM read). Remove clears
// the running id if it matches; else it searches from the head, reading
// and comparing each entry, then shifts later entries forward, reading and
// writing each entry, paced by the single registered RAM read port.
// Reset clears head, tail, count and the running slot; RAM is not cleared.
// A stalled response holds the finished command in the done state; no new
// command is taken until the response register loads.
// ----------------------------------------------------------------------------
`default_nettype none

module ready_queue_scheduler #(
   parameter int QUEUE_DEPTH = rqs_pkg::QueueDepthDefault,
   parameter int ID_BITS     = rqs_pkg::IdBitsDefault
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire rqs_pkg::req_payload_type req_payload,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      rqs_pkg::rsp_payload_type rsp_payload
);

   localparam int IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOT_W = (ID_BITS < rqs_pkg::PID_W) ? ID_BITS : rqs_pkg::PID_W;
   localparam logic [IDX_W-1:0] LastIdx = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FullCnt = CNT_W'(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_DONE
   } state_type;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      return (idx == LastIdx) ? '0 : IDX_W'(idx + 1'b1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? LastIdx : IDX_W'(idx - 1'b1);
   endfunction

   state_type                 state_ff, state_in;
   rqs_pkg::req_payload_type  req_ff, req_in;
   logic [IDX_W-1:0]          head_ff, head_in;
   logic [IDX_W-1:0]          tail_ff, tail_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      run_valid_ff, run_valid_in;
   logic [SLOT_W-1:0]         run_id_ff, run_id_in;
   logic [IDX_W-1:0]          ptr_ff, ptr_in;
   logic [CNT_W-1:0]          k_ff, k_in;
   logic                      status_ff, status_in;
   logic                      popped_valid_ff, popped_valid_in;
   logic [SLOT_W-1:0]         popped_id_ff, popped_id_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rqs_pkg::rsp_payload_type  rsp_ff, rsp_in;

   logic                      ram_wr_en;
   logic [IDX_W-1:0]          ram_wr_addr;
   logic [SLOT_W-1:0]         ram_wr_data;
   logic                      ram_rd_en;
   logic [IDX_W-1:0]          ram_rd_addr;
   logic [SLOT_W-1:0]         ram_rd_data;

   logic [SLOT_W-1:0]         req_id;
   logic                      q_empty;
   logic                      q_full;
   logic                      out_free;

   rqs_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_id   = req_ff.process_id[SLOT_W-1:0];
   assign q_empty  = (count_ff == '0);
   assign q_full   = (count_ff == FullCnt);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      run_valid_in    = run_valid_ff;
      run_id_in       = run_id_ff;
      ptr_in          = ptr_ff;
      k_in            = k_ff;
      status_in       = status_ff;
      popped_valid_in = popped_valid_ff;
      popped_id_in    = popped_id_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_in          = rsp_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = tail_ff;
      ram_wr_data     = ram_rd_data;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            status_in       = rqs_pkg::STATUS_FAIL;
            popped_valid_in = 1'b0;
            popped_id_in    = '0;
            state_in        = ST_DONE;
            case (req_ff.command)
               rqs_pkg::CMD_ADD: begin
                  if (!q_full) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = req_id;
                     tail_in     = idx_inc(tail_ff);
                     count_in    = CNT_W'(count_ff + 1'b1);
                     status_in   = rqs_pkg::STATUS_OK;
                  end
               end
               rqs_pkg::CMD_REMOVE: begin
                  if (run_valid_ff && run_id_ff == req_id) begin
                     run_valid_in = 1'b0;
                     run_id_in    = '0;
                     status_in    = rqs_pkg::STATUS_OK;
                  end else begin
                     ptr_in   = head_ff;
                     k_in     = '0;
                     state_in = ST_SRCH_RD;
                  end
               end
               rqs_pkg::CMD_NEXT: begin
                  if (!q_empty) begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_POP;
                  end
               end
               rqs_pkg::CMD_DISPATCH: begin
                  if (!run_valid_ff && !q_empty) begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_POP;
                  end
               end
               rqs_pkg::CMD_YIELD: begin
                  if (run_valid_ff && !q_full && req_ff.transition_ok) begin
                     ram_wr_en    = 1'b1;
                     ram_wr_data  = run_id_ff;
                     tail_in      = idx_inc(tail_ff);
                     count_in     = CNT_W'(count_ff + 1'b1);
                     run_valid_in = 1'b0;
                     run_id_in    = '0;
                     status_in    = rqs_pkg::STATUS_OK;
                  end
               end
               default: begin
                  status_in = rqs_pkg::STATUS_FAIL;
               end
            endcase
         end

         ST_POP: begin
            head_in  = idx_inc(head_ff);
            state_in = ST_DONE;
            if (req_ff.command == rqs_pkg::CMD_NEXT) begin
               count_in        = CNT_W'(count_ff - 1'b1);
               popped_valid_in = 1'b1;
               popped_id_in    = ram_rd_data;
               status_in       = rqs_pkg::STATUS_OK;
            end else if (req_ff.transition_ok) begin
               count_in     = CNT_W'(count_ff - 1'b1);
               run_valid_in = 1'b1;
               run_id_in    = ram_rd_data;
               status_in    = rqs_pkg::STATUS_OK;
            end else begin
               // transition refused: head id goes back to the tail, count holds
               ram_wr_en = 1'b1;
               tail_in   = idx_inc(tail_ff);
            end
         end

         ST_SRCH_RD: begin
            if (k_ff == count_ff) begin
               state_in = ST_DONE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_ff;
               state_in    = ST_SRCH_CMP;
            end
         end

         ST_SRCH_CMP: begin
            if (ram_rd_data == req_id) begin
               state_in = ST_SHIFT_RD;
            end else begin
               ptr_in   = idx_inc(ptr_ff);
               k_in     = CNT_W'(k_ff + 1'b1);
               state_in = ST_SRCH_RD;
            end
         end

         ST_SHIFT_RD: begin
            if (CNT_W'(k_ff + 1'b1) == count_ff) begin
               tail_in   = idx_dec(tail_ff);
               count_in  = CNT_W'(count_ff - 1'b1);
               status_in = rqs_pkg::STATUS_OK;
               state_in  = ST_DONE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_inc(ptr_ff);
               state_in    = ST_SHIFT_WR;
            end
         end

         ST_SHIFT_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_ff;
            ptr_in      = idx_inc(ptr_ff);
            k_in        = CNT_W'(k_ff + 1'b1);
            state_in    = ST_SHIFT_RD;
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = status_ff;
               rsp_in.popped_valid   = popped_valid_ff;
               rsp_in.popped_id      = rqs_pkg::PID_W'(popped_id_ff);
               rsp_in.running_valid  = run_valid_ff;
               rsp_in.running_id     = run_valid_ff ? rqs_pkg::PID_W'(run_id_ff) : '0;
               rsp_in.ready_count    = rqs_pkg::COUNT_W'(count_ff);
               state_in              = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff          <= req_in;
      ptr_ff          <= ptr_in;
      k_ff            <= k_in;
      status_ff       <= status_in;
      popped_valid_ff <= popped_valid_in;
      popped_id_ff    <= popped_id_in;
      rsp_ff          <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         run_valid_ff <= 1'b0;
         run_id_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         run_valid_ff <= run_valid_in;
         run_id_ff    <= run_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

### rtl/rqs_checker.sv
// ----------------------------------------------------------------------------
// rqs_checker
// Port-level checks for the ready queue scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rqs_checker (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_stall,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire rqs_pkg::rsp_payload_type rsp_payload
);

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response beat changed");

   // one command in flight: an accepted beat stalls the next cycle
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second command taken while one is in flight");

   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.popped_valid |-> rsp_payload.status == rqs_pkg::STATUS_OK)
      else $error("popped id reported on a failed command");

   a_pop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.popped_valid |-> rsp_payload.popped_id == '0)
      else $error("popped id nonzero without a pop");

   a_run_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.running_valid |-> rsp_payload.running_id == '0)
      else $error("running id nonzero with nothing running");

endmodule

bind ready_queue_scheduler rqs_checker u_rqs_checker (.*);

`default_nettype wire
